### hdl/butterworth_frequency_mask_gain_core_assert.svh
// ----------------------------------------------------------------------------
// Butterworth mask gain assertion macros
// Concurrent assertion wrappers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BUTTERWORTH_FREQUENCY_MASK_GAIN_CORE_ASSERT_SVH
`define BUTTERWORTH_FREQUENCY_MASK_GAIN_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BWMG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bwmg assertion failed");
`define BWMG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  `BWMG_ASSERT(lbl, clk, rstn, (ante) |-> (cons))
`else
`define BWMG_ASSERT(lbl, clk, rstn, prop)
`define BWMG_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/bwmg_pkg.sv
// ----------------------------------------------------------------------------
// Butterworth mask gain package
// Widths, register codes, stage layout and pipeline step functions.
// ----------------------------------------------------------------------------
package bwmg_pkg;

  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned MaxOrder = 8;
  localparam int unsigned GainBits = 16;

  localparam int unsigned CfgW   = 13;
  localparam int unsigned OrdW   = 4;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CoordW = 12;
  localparam int unsigned OffW   = 15;
  localparam int unsigned SqW    = 26;
  localparam int unsigned DistW  = 27;
  localparam int unsigned DenW   = 28;
  localparam int unsigned FracW  = 16;
  localparam int unsigned QW     = 32;
  localparam int unsigned ProdW  = 2 * QW;
  localparam int unsigned GDenW  = QW + 1;
  localparam int unsigned GQW    = GainBits + 1;
  localparam int unsigned NumW   = QW + GainBits + 1;

  // stage layout of the valid chain
  localparam int unsigned QStages  = QW;
  localparam int unsigned PwStages = 2 * MaxOrder;
  localparam int unsigned GStages  = GQW;
  localparam int unsigned SQ0      = 3;
  localparam int unsigned SPW0     = SQ0 + QStages + 1;
  localparam int unsigned SFD0     = SPW0 + PwStages + 1;
  localparam int unsigned SOUT     = SFD0 + GStages + 1;
  localparam int unsigned NStg     = SOUT + 1;

  localparam logic [CfgW-1:0] HeightReset = CfgW'(512);
  localparam logic [CfgW-1:0] WidthReset  = CfgW'(512);
  localparam logic [CfgW-1:0] CutoffReset = CfgW'(320);
  localparam logic [OrdW-1:0] OrderReset  = OrdW'(5);
  localparam logic [DenW-1:0] DenReset    = DenW'(4 * 320 * 320);
  localparam logic [QW-1:0]   OneQ16      = QW'(1 << FracW);

  typedef enum logic [IdxW-1:0] {
    CFG_HEIGHT = 3'd0,
    CFG_WIDTH  = 3'd1,
    CFG_CUTOFF = 3'd2,
    CFG_ORDER  = 3'd3,
    CFG_HPASS  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic            zero;
    logic            sat;
    logic [DenW-1:0] rem;
    logic [QW-1:0]   lo;
    logic [QW-1:0]   quot;
  } qdiv_t;

  typedef struct packed {
    logic             zero;
    logic [QW-1:0]    p;
    logic [QW-1:0]    q;
    logic [ProdW-1:0] prod;
  } pow_t;

  typedef struct packed {
    logic [GDenW-1:0] rem;
    logic [GQW-1:0]   lo;
    logic [GQW-1:0]   quot;
    logic [GDenW-1:0] den;
  } gdiv_t;

  // one restoring step of the distance ratio divider
  function automatic qdiv_t qdiv_step(qdiv_t s, logic [DenW-1:0] den);
    logic [DenW:0] t;
    logic          ge;
    qdiv_t         r;
    t      = {s.rem, s.lo[QW-1]};
    ge     = (t >= {1'b0, den});
    r      = s;
    r.rem  = DenW'(ge ? (t - {1'b0, den}) : t);
    r.lo   = {s.lo[QW-2:0], 1'b0};
    r.quot = {s.quot[QW-2:0], ge};
    return r;
  endfunction

  // one restoring step of the gain divider
  function automatic gdiv_t gdiv_step(gdiv_t s);
    logic [GDenW:0] t;
    logic           ge;
    gdiv_t          r;
    t      = {s.rem, s.lo[GQW-1]};
    ge     = (t >= {1'b0, s.den});
    r      = s;
    r.rem  = GDenW'(ge ? (t - {1'b0, s.den}) : t);
    r.lo   = {s.lo[GQW-2:0], 1'b0};
    r.quot = {s.quot[GQW-2:0], ge};
    return r;
  endfunction

endpackage

### hdl/bwmg_if.sv
// ----------------------------------------------------------------------------
// Butterworth mask gain channels
// Valid/ready channels for bin requests and gain results.
// ----------------------------------------------------------------------------
interface bwmg_in_if import bwmg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] bin_row;
  logic [CoordW-1:0] bin_col;

  modport source (output valid, output bin_row, output bin_col, input ready);
  modport sink   (input valid, input bin_row, input bin_col, output ready);
endinterface

interface bwmg_out_if import bwmg_pkg::*;;
  logic                valid;
  logic                ready;
  logic [GainBits-1:0] gain;

  modport source (output valid, output gain, input ready);
  modport sink   (input valid, input gain, output ready);
endinterface

### hdl/butterworth_frequency_mask_gain_core.sv
// Throughput: one request per cycle; the whole pipeline holds while the output is stalled.
// Depth is set by the 32-step ratio divider, 8 multiply/saturate pairs and 17-step gain divider.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// Butterworth frequency mask gain core
// Pipelined Butterworth low/high-pass gain per frequency bin.
// ----------------------------------------------------------------------------
`include "butterworth_frequency_mask_gain_core_assert.svh"

module butterworth_frequency_mask_gain_core import bwmg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  bwmg_in_if.sink         in_i,
  bwmg_out_if.source      out_o
);

  logic [CfgW-1:0] height_q, width_q, cutoff_q;
  logic [OrdW-1:0] order_q;
  logic            hp_q;
  logic [DenW-1:0] den_q;
  logic [SqW-1:0]  d0sq;

  assign d0sq = SqW'(cutoff_q) * SqW'(cutoff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightReset;
      width_q  <= WidthReset;
      cutoff_q <= CutoffReset;
      order_q  <= OrderReset;
      hp_q     <= 1'b0;
      den_q    <= DenReset;
    end else begin
      den_q <= {d0sq, 2'b00};
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_CUTOFF: cutoff_q <= cfg_data_i;
          CFG_ORDER:  order_q  <= cfg_data_i[OrdW-1:0];
          CFG_HPASS:  hp_q     <= cfg_data_i[0];
          default:    ;
        endcase
      end
    end
  end

  logic [CfgW-1:0] hgt, wid;
  logic [OrdW-1:0] n_eff;

  assign hgt   = (height_q > CfgW'(MaxDim)) ? CfgW'(MaxDim) : height_q;
  assign wid   = (width_q > CfgW'(MaxDim)) ? CfgW'(MaxDim) : width_q;
  assign n_eff = (order_q > OrdW'(MaxOrder)) ? OrdW'(MaxOrder) : order_q;

  // global advance: every stage moves together
  logic            adv;
  logic [NStg-1:0] vld_q;

  assign adv         = !vld_q[NStg-1] || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_i.valid};
    end
  end

  // front: offsets, squares, distance
  logic signed [OffW-1:0]   dr_d, dc_d, dr_q, dc_q;
  logic signed [2*OffW-1:0] drsq, dcsq;
  logic [SqW-1:0]           dr2_q, dc2_q;
  logic [DistW-1:0]         dist_q;

  assign dr_d = OffW'({1'b0, in_i.bin_row, 1'b0}) - OffW'(hgt);
  assign dc_d = OffW'({1'b0, in_i.bin_col, 1'b0}) - OffW'(wid);
  assign drsq = dr_q * dr_q;
  assign dcsq = dc_q * dc_q;

  // ratio divider
  qdiv_t qd_d [0:QStages];
  qdiv_t qd_q [0:QStages];

  always_comb begin
    qd_d[0].zero = (dist_q == '0);
    qd_d[0].sat  = (DenW'(dist_q[DistW-1:FracW]) >= den_q);
    qd_d[0].rem  = DenW'(dist_q[DistW-1:FracW]);
    qd_d[0].lo   = {dist_q[FracW-1:0], {(QW-FracW){1'b0}}};
    qd_d[0].quot = '0;
  end

  for (genvar k = 0; k < QStages; k++) begin : g_qdiv
    assign qd_d[k+1] = qdiv_step(qd_q[k], den_q);
  end

  // power chain: odd stages multiply, even stages below the effective order scale and saturate
  pow_t pw_d [0:PwStages];
  pow_t pw_q [0:PwStages];

  always_comb begin
    pw_d[0].zero = qd_q[QStages].zero;
    pw_d[0].p    = OneQ16;
    pw_d[0].q    = qd_q[QStages].zero ? '0 :
                   (qd_q[QStages].sat ? '1 : qd_q[QStages].quot);
    pw_d[0].prod = '0;
  end

  for (genvar s = 1; s <= PwStages; s++) begin : g_pow
    if (s % 2 == 1) begin : g_mul
      always_comb begin
        pw_d[s]      = pw_q[s-1];
        pw_d[s].prod = ProdW'(pw_q[s-1].p) * ProdW'(pw_q[s-1].q);
      end
    end else begin : g_sat
      localparam logic [OrdW-1:0] Step = OrdW'(s / 2 - 1);
      always_comb begin
        pw_d[s] = pw_q[s-1];
        if (Step < n_eff) begin
          pw_d[s].p = (|pw_q[s-1].prod[ProdW-1:QW+FracW]) ? '1 :
                      pw_q[s-1].prod[QW+FracW-1:FracW];
        end
      end
    end
  end

  // gain divider: (num * 2^16 + den/2) / den, den = 1.0 + p
  gdiv_t            fd_d [0:GStages];
  gdiv_t            fd_q [0:GStages];
  logic [GDenW-1:0] gden;
  logic [NumW-1:0]  gnum, gsum;

  assign gden = GDenW'(pw_q[PwStages].p) + GDenW'(OneQ16);
  assign gnum = hp_q ? (pw_q[PwStages].zero ? '0 :
                        {1'b0, pw_q[PwStages].p, {GainBits{1'b0}}}) :
                       (NumW'(OneQ16) << GainBits);
  assign gsum = gnum + NumW'(gden >> 1);

  always_comb begin
    fd_d[0].rem  = GDenW'(gsum[NumW-1:GQW]);
    fd_d[0].lo   = gsum[GQW-1:0];
    fd_d[0].quot = '0;
    fd_d[0].den  = gden;
  end

  for (genvar k = 0; k < GStages; k++) begin : g_gdiv
    assign fd_d[k+1] = gdiv_step(fd_q[k]);
  end

  logic [GainBits-1:0] gain_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dr_q   <= dr_d;
      dc_q   <= dc_d;
      dr2_q  <= drsq[SqW-1:0];
      dc2_q  <= dcsq[SqW-1:0];
      dist_q <= DistW'(dr2_q) + DistW'(dc2_q);
      qd_q   <= qd_d;
      pw_q   <= pw_d;
      fd_q   <= fd_d;
      // clamp the unit gain to the largest code
      gain_q <= fd_q[GStages].quot[GQW-1] ? '1 : fd_q[GStages].quot[GainBits-1:0];
    end
  end

  assign out_o.gain = gain_q;

  `BWMG_ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni, out_o.valid && !out_o.ready, !in_i.ready)
  `BWMG_ASSERT_IMPL(a_hold_keeps_valids, clk_i, rst_ni, !adv, ##1 $stable(vld_q))
  `BWMG_ASSERT_IMPL(a_gain_quot_range, clk_i, rst_ni, vld_q[SOUT-1], fd_q[GStages].quot <= GQW'(1 << GainBits))

endmodule
